FILE: sv/four_shift_average_fragment_filter_top_macros.svh
// Assertion macros for the shift-average filter top level.
// Needs clk and rst_n in the scope where a macro is used.
`ifndef FOUR_SHIFT_AVERAGE_FRAGMENT_FILTER_TOP_MACROS_SVH
`define FOUR_SHIFT_AVERAGE_FRAGMENT_FILTER_TOP_MACROS_SVH

// Condition must hold at every clock edge out of reset.
`define FSAFF_ASSERT_HOLDS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Consequent must hold in the same cycle as the antecedent.
`define FSAFF_ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

FILE: sv/fsaff_pkg.sv
// Shared constants, codes and types of the shift-average filter.
// No dependencies.
`default_nettype none

package fsaff_pkg;

  localparam int MAX_WIDTH    = 1024;
  localparam int MAX_OFFSET   = 8;
  localparam int RING_ROWS    = 2 * MAX_OFFSET + 1;
  localparam int HEIGHT_LIMIT = 4096;

  localparam int PIX_W = 24;
  localparam int CH_W  = 8;
  localparam int N_CH  = PIX_W / CH_W;

  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int RING_W = $clog2(RING_ROWS);
  localparam int ROW_W  = $clog2(HEIGHT_LIMIT + 1);
  localparam int Y_W    = $clog2(HEIGHT_LIMIT);

  localparam int OFS_W      = 4;
  localparam int WID_W      = 11;
  localparam int HGT_W      = 13;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;

  localparam int FLAT_DEPTH = RING_ROWS * MAX_WIDTH;

  localparam int FIFO_DEPTH = 8;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

  localparam logic [OFS_W-1:0] OFS_RST = 4'd5;
  localparam logic [WID_W-1:0] WID_RST = 11'd640;
  localparam logic [HGT_W-1:0] HGT_RST = 13'd480;

  localparam logic [CFG_IDX_W-1:0] REG_SHIFT_OFFSET = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd2;

  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_DRAIN = 1'b1;

  // One accepted beat as decided by the scheduler.
  typedef struct packed {
    logic              res;
    logic              we;
    logic [RING_W-1:0] wring;
    logic [COL_W-1:0]  wcol;
    logic [RING_W-1:0] yring;
    logic [COL_W-1:0]  x;
    logic [OFS_W-1:0]  ofs;
    logic              up_ok;
    logic              down_ok;
    logic              left_ok;
    logic              right_ok;
    logic              eol;
    logic              eof;
  } step_t;

endpackage

`default_nettype wire

FILE: sv/fsaff_if.sv
// Handshake channels of the shift-average filter: pixel in, result out, config.
// Depends on fsaff_pkg.
`default_nettype none

interface fsaff_in_if;
  import fsaff_pkg::*;
  logic             valid;
  logic             ready;
  logic             op;
  logic [PIX_W-1:0] pixel_rgb;
  modport source (output valid, op, pixel_rgb, input ready);
  modport sink   (input valid, op, pixel_rgb, output ready);
endinterface

interface fsaff_out_if;
  import fsaff_pkg::*;
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] result_rgb;
  logic             end_of_line;
  logic             end_of_frame;
  modport source (output valid, result_rgb, end_of_line, end_of_frame, input ready);
  modport sink   (input valid, result_rgb, end_of_line, end_of_frame, output ready);
endinterface

interface fsaff_cfg_if;
  import fsaff_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  idx;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, idx, data, input ready);
  modport sink   (input valid, idx, data, output ready);
endinterface

`default_nettype wire

FILE: sv/fsaff_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module fsaff_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // read returns old data on a same-address write
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

FILE: sv/fsaff_sched.sv
// Config registers and raster counters: decides per beat what is written and output.
// Depends on fsaff_pkg.
`default_nettype none

module fsaff_sched (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [fsaff_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [fsaff_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                            beat,
  input  logic                            op,
  output fsaff_pkg::step_t                step
);
  import fsaff_pkg::*;

  logic [OFS_W-1:0]  ofs_r, ofs_nxt;
  logic [WID_W-1:0]  wid_r, wid_nxt;
  logic [HGT_W-1:0]  hgt_r, hgt_nxt;
  logic [COL_W-1:0]  icol_r, icol_nxt, icol_stp;
  logic [ROW_W-1:0]  irow_r, irow_nxt, irow_stp;
  logic [RING_W-1:0] iring_r, iring_nxt, iring_stp;
  logic [COL_W-1:0]  ocol_r, ocol_nxt, ocol_stp;
  logic [Y_W-1:0]    orow_r, orow_nxt, orow_stp;
  logic [RING_W-1:0] oring_r, oring_nxt, oring_stp;

  logic              done0, done_n, wr, ignored, col_wrap, in_front, res, eol, eof;
  logic              cfg_hit;
  logic [COL_W:0]    col_inc, ocol_inc;
  logic [ROW_W-1:0]  row_inc, y_ext, yd, orow_inc;
  logic [RING_W-1:0] iring_inc, oring_inc;
  logic [OFS_W-1:0]  ofs_sat;
  logic [WID_W-1:0]  wid_raw, wid_sat;
  logic [HGT_W-1:0]  hgt_raw, hgt_sat;

  // input side
  always_comb begin
    done0     = irow_r >= ROW_W'(hgt_r);
    wr        = beat && (op == OP_PIXEL) && !done0;
    ignored   = (op == OP_DRAIN) && !done0;
    col_inc   = {1'b0, icol_r} + 1'b1;
    col_wrap  = col_inc >= (COL_W+1)'(wid_r);
    row_inc   = irow_r + 1'b1;
    iring_inc = (iring_r == RING_W'(RING_ROWS - 1)) ? '0 : iring_r + 1'b1;
    icol_stp  = icol_r;
    irow_stp  = irow_r;
    iring_stp = iring_r;
    if (wr) begin
      if (col_wrap) begin
        icol_stp  = '0;
        irow_stp  = row_inc;
        iring_stp = iring_inc;
      end else begin
        icol_stp = col_inc[COL_W-1:0];
      end
    end
    done_n = irow_stp >= ROW_W'(hgt_r);
  end

  // output side
  always_comb begin
    y_ext     = ROW_W'(orow_r);
    yd        = y_ext + ROW_W'(ofs_r);
    in_front  = (irow_stp > yd) || ((irow_stp == yd) && (icol_stp > ocol_r));
    res       = beat && !ignored && (y_ext < ROW_W'(hgt_r)) && (done_n || in_front);
    ocol_inc  = {1'b0, ocol_r} + 1'b1;
    orow_inc  = y_ext + 1'b1;
    eol       = ocol_inc >= (COL_W+1)'(wid_r);
    eof       = eol && (orow_inc >= ROW_W'(hgt_r));
    oring_inc = (oring_r == RING_W'(RING_ROWS - 1)) ? '0 : oring_r + 1'b1;
    ocol_stp  = ocol_r;
    orow_stp  = orow_r;
    oring_stp = oring_r;
    if (res) begin
      if (eol) begin
        ocol_stp  = '0;
        orow_stp  = Y_W'(orow_inc);
        oring_stp = oring_inc;
      end else begin
        ocol_stp = ocol_inc[COL_W-1:0];
      end
    end
  end

  // register writes saturate into range
  always_comb begin
    ofs_sat = (cfg_data[OFS_W-1:0] > OFS_W'(MAX_OFFSET)) ? OFS_W'(MAX_OFFSET)
                                                         : cfg_data[OFS_W-1:0];
    wid_raw = cfg_data[WID_W-1:0];
    if (wid_raw == '0) begin
      wid_sat = WID_W'(1);
    end else if (wid_raw > WID_W'(MAX_WIDTH)) begin
      wid_sat = WID_W'(MAX_WIDTH);
    end else begin
      wid_sat = wid_raw;
    end
    hgt_raw = cfg_data[HGT_W-1:0];
    if (hgt_raw == '0) begin
      hgt_sat = HGT_W'(1);
    end else if (hgt_raw > HGT_W'(HEIGHT_LIMIT)) begin
      hgt_sat = HGT_W'(HEIGHT_LIMIT);
    end else begin
      hgt_sat = hgt_raw;
    end
  end

  always_comb begin
    ofs_nxt = ofs_r;
    wid_nxt = wid_r;
    hgt_nxt = hgt_r;
    cfg_hit = 1'b0;
    if (cfg_we) begin
      case (cfg_idx)
        REG_SHIFT_OFFSET: begin
          ofs_nxt = ofs_sat;
          cfg_hit = 1'b1;
        end
        REG_IMAGE_WIDTH: begin
          wid_nxt = wid_sat;
          cfg_hit = 1'b1;
        end
        REG_IMAGE_HEIGHT: begin
          hgt_nxt = hgt_sat;
          cfg_hit = 1'b1;
        end
        default: begin
          cfg_hit = 1'b0;
        end
      endcase
    end
    // a register write or the last output beat restarts the frame
    if (cfg_hit || (res && eof)) begin
      icol_nxt  = '0;
      irow_nxt  = '0;
      iring_nxt = '0;
      ocol_nxt  = '0;
      orow_nxt  = '0;
      oring_nxt = '0;
    end else begin
      icol_nxt  = icol_stp;
      irow_nxt  = irow_stp;
      iring_nxt = iring_stp;
      ocol_nxt  = ocol_stp;
      orow_nxt  = orow_stp;
      oring_nxt = oring_stp;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ofs_r   <= OFS_RST;
      wid_r   <= WID_RST;
      hgt_r   <= HGT_RST;
      icol_r  <= '0;
      irow_r  <= '0;
      iring_r <= '0;
      ocol_r  <= '0;
      orow_r  <= '0;
      oring_r <= '0;
    end else begin
      ofs_r   <= ofs_nxt;
      wid_r   <= wid_nxt;
      hgt_r   <= hgt_nxt;
      icol_r  <= icol_nxt;
      irow_r  <= irow_nxt;
      iring_r <= iring_nxt;
      ocol_r  <= ocol_nxt;
      orow_r  <= orow_nxt;
      oring_r <= oring_nxt;
    end
  end

  always_comb begin
    step.res      = res;
    step.we       = wr;
    step.wring    = iring_r;
    step.wcol     = icol_r;
    step.yring    = oring_r;
    step.x        = ocol_r;
    step.ofs      = ofs_r;
    step.up_ok    = y_ext >= ROW_W'(ofs_r);
    step.down_ok  = yd < ROW_W'(hgt_r);
    step.left_ok  = {1'b0, ocol_r} >= (COL_W+1)'(ofs_r);
    step.right_ok = ({1'b0, ocol_r} + (COL_W+1)'(ofs_r)) < (COL_W+1)'(wid_r);
    step.eol      = eol;
    step.eof      = eof;
  end

endmodule

`default_nettype wire

FILE: sv/four_shift_average_fragment_filter_top.sv
// Four-neighbour shift-average filter, top level; needs fsaff_pkg, fsaff_if, fsaff_sched, fsaff_ram.
// Path: a result beat is offered once the input beat that releases it has passed the
//   scheduler register, RAM read, neighbour select and output fifo; results trail by offset rows.
// Throughput: 1 input beat per clock; ready drops only while 8 result beats are owed downstream.
// Reset: synchronous, active low; clears counters, fifo and config (offset 5, 640 x 480).
//   The row RAMs are not cleared.
`default_nettype none
`include "four_shift_average_fragment_filter_top_macros.svh"

module four_shift_average_fragment_filter_top (
  input  logic         clk,
  input  logic         rst_n,
  fsaff_in_if.sink     in_ch,
  fsaff_out_if.source  out_ch,
  fsaff_cfg_if.sink    cfg_ch
);
  import fsaff_pkg::*;

  // neighbour reads that coincide with the write of the same beat
  typedef struct packed {
    logic c;
    logic u;
    logic d;
    logic l;
    logic r;
  } hit_t;

  typedef struct packed {
    logic              vld;
    hit_t              hit;
    logic [PIX_W-1:0]  wdata;
    logic [RING_W-1:0] bc;
    logic [RING_W-1:0] bu;
    logic [RING_W-1:0] bd;
    logic              up_ok;
    logic              down_ok;
    logic              left_ok;
    logic              right_ok;
    logic              eol;
    logic              eof;
  } sel_t;

  typedef struct packed {
    logic             vld;
    logic [PIX_W-1:0] up;
    logic [PIX_W-1:0] down;
    logic [PIX_W-1:0] left;
    logic [PIX_W-1:0] right;
    logic             eol;
    logic             eof;
  } nbr_t;

  typedef struct packed {
    logic [PIX_W-1:0] rgb;
    logic             eol;
    logic             eof;
  } res_t;

  function automatic logic [PIX_W-1:0] avg4(input logic [PIX_W-1:0] a,
                                           input logic [PIX_W-1:0] b,
                                           input logic [PIX_W-1:0] c,
                                           input logic [PIX_W-1:0] d);
    logic [PIX_W-1:0] acc;
    logic [CH_W+1:0]  s;
    acc = '0;
    for (int k = 0; k < N_CH; k++) begin
      s = (CH_W+2)'(a[k*CH_W +: CH_W]) + (CH_W+2)'(b[k*CH_W +: CH_W])
        + (CH_W+2)'(c[k*CH_W +: CH_W]) + (CH_W+2)'(d[k*CH_W +: CH_W])
        + (CH_W+2)'(2);
      acc[k*CH_W +: CH_W] = s[CH_W+1:2];
    end
    return acc;
  endfunction

  // ---------------------------------------------------------------
  // Handshake. Every beat that will yield a result takes a credit,
  // given back when the result leaves the fifo, so the fifo can never
  // overflow and the pipeline itself never stalls.
  // ---------------------------------------------------------------
  logic             in_ready, in_beat, out_pop;
  logic [CNT_W-1:0] credit_r, credit_nxt;
  step_t            step;

  assign in_ready     = credit_r < CNT_W'(FIFO_DEPTH);
  assign in_ch.ready  = in_ready;
  assign in_beat      = in_ch.valid && in_ready;
  assign cfg_ch.ready = 1'b1;

  fsaff_sched u_sched (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_ch.valid),
    .cfg_idx  (cfg_ch.idx),
    .cfg_data (cfg_ch.data),
    .beat     (in_beat),
    .op       (in_ch.op),
    .step     (step)
  );

  // ---------------------------------------------------------------
  // Stage A: scheduler decision and the incoming pixel.
  // ---------------------------------------------------------------
  step_t            a_r;
  logic [PIX_W-1:0] a_pix_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_r <= '0;
    end else begin
      a_r <= step;
    end
  end

  always_ff @(posedge clk) begin
    a_pix_r <= in_ch.pixel_rgb;
  end

  // ---------------------------------------------------------------
  // Stage B: ring rows of the neighbours, RAM write and reads.
  // Up, centre and down share column x in up to three ring rows,
  // so the column RAM is banked by ring row. Left and right sit in
  // the centre row at columns x - offset and x + offset and get a full copy each.
  // ---------------------------------------------------------------
  logic [RING_W:0]          y_x, ofs_x, dn_sum;
  logic [RING_W-1:0]        bu, bd;
  logic [COL_W-1:0]         left_col, right_col;
  logic [PIX_W-1:0]         col_q [RING_ROWS];
  logic [PIX_W-1:0]         left_q, right_q;
  logic [RING_W+COL_W-1:0]  wr_flat;
  hit_t                     hit;
  sel_t                     b_nxt, b_r;

  always_comb begin
    y_x       = {1'b0, a_r.yring};
    ofs_x     = (RING_W+1)'(a_r.ofs);
    dn_sum    = y_x + ofs_x;
    bu        = (y_x >= ofs_x) ? RING_W'(y_x - ofs_x)
                               : RING_W'(y_x + (RING_W+1)'(RING_ROWS) - ofs_x);
    bd        = (dn_sum >= (RING_W+1)'(RING_ROWS)) ? RING_W'(dn_sum - (RING_W+1)'(RING_ROWS))
                                                    : RING_W'(dn_sum);
    left_col  = a_r.x - COL_W'(a_r.ofs);
    right_col = a_r.x + COL_W'(a_r.ofs);
    wr_flat   = {a_r.wring, a_r.wcol};
  end

  for (genvar g = 0; g < RING_ROWS; g++) begin : g_bank
    fsaff_ram #(
      .WIDTH (PIX_W),
      .DEPTH (MAX_WIDTH)
    ) u_col_ram (
      .clk     (clk),
      .wr_en   (a_r.we && (a_r.wring == RING_W'(g))),
      .wr_addr (a_r.wcol),
      .wr_data (a_pix_r),
      .rd_addr (a_r.x),
      .rd_data (col_q[g])
    );
  end

  fsaff_ram #(
    .WIDTH (PIX_W),
    .DEPTH (FLAT_DEPTH)
  ) u_left_ram (
    .clk     (clk),
    .wr_en   (a_r.we),
    .wr_addr (wr_flat),
    .wr_data (a_pix_r),
    .rd_addr ({a_r.yring, left_col}),
    .rd_data (left_q)
  );

  fsaff_ram #(
    .WIDTH (PIX_W),
    .DEPTH (FLAT_DEPTH)
  ) u_right_ram (
    .clk     (clk),
    .wr_en   (a_r.we),
    .wr_addr (wr_flat),
    .wr_data (a_pix_r),
    .rd_addr ({a_r.yring, right_col}),
    .rd_data (right_q)
  );

  // The model writes before it reads, so a read of the address being
  // written this cycle takes the new pixel (typically the down neighbour).
  always_comb begin
    hit.c = a_r.we && (a_r.wring == a_r.yring) && (a_r.wcol == a_r.x);
    hit.u = a_r.we && (a_r.wring == bu) && (a_r.wcol == a_r.x);
    hit.d = a_r.we && (a_r.wring == bd) && (a_r.wcol == a_r.x);
    hit.l = a_r.we && (a_r.wring == a_r.yring) && (a_r.wcol == left_col);
    hit.r = a_r.we && (a_r.wring == a_r.yring) && (a_r.wcol == right_col);

    b_nxt.vld      = a_r.res;
    b_nxt.hit      = hit;
    b_nxt.wdata    = a_pix_r;
    b_nxt.bc       = a_r.yring;
    b_nxt.bu       = bu;
    b_nxt.bd       = bd;
    b_nxt.up_ok    = a_r.up_ok;
    b_nxt.down_ok  = a_r.down_ok;
    b_nxt.left_ok  = a_r.left_ok;
    b_nxt.right_ok = a_r.right_ok;
    b_nxt.eol      = a_r.eol;
    b_nxt.eof      = a_r.eof;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_r <= '0;
    end else begin
      b_r <= b_nxt;
    end
  end

  // ---------------------------------------------------------------
  // Stage C: pick each neighbour from its bank or the bypass; a
  // neighbour outside the image falls back to the centre pixel.
  // ---------------------------------------------------------------
  logic [PIX_W-1:0] centre, up_raw, down_raw, left_raw, right_raw;
  nbr_t             c_nxt, c_r;

  always_comb begin
    centre    = b_r.hit.c ? b_r.wdata : col_q[b_r.bc];
    up_raw    = b_r.hit.u ? b_r.wdata : col_q[b_r.bu];
    down_raw  = b_r.hit.d ? b_r.wdata : col_q[b_r.bd];
    left_raw  = b_r.hit.l ? b_r.wdata : left_q;
    right_raw = b_r.hit.r ? b_r.wdata : right_q;

    c_nxt.vld   = b_r.vld;
    c_nxt.up    = b_r.up_ok    ? up_raw    : centre;
    c_nxt.down  = b_r.down_ok  ? down_raw  : centre;
    c_nxt.left  = b_r.left_ok  ? left_raw  : centre;
    c_nxt.right = b_r.right_ok ? right_raw : centre;
    c_nxt.eol   = b_r.eol;
    c_nxt.eof   = b_r.eof;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_r <= '0;
    end else begin
      c_r <= c_nxt;
    end
  end

  // ---------------------------------------------------------------
  // Stage D: per-channel rounded average, written into the fifo.
  // ---------------------------------------------------------------
  res_t               res_nxt;
  res_t               fifo_mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]   fifo_cnt_r, fifo_cnt_nxt;
  res_t               head;

  always_comb begin
    res_nxt.rgb = avg4(c_r.up, c_r.down, c_r.left, c_r.right);
    res_nxt.eol = c_r.eol;
    res_nxt.eof = c_r.eof;
  end

  always_ff @(posedge clk) begin
    if (c_r.vld) begin
      fifo_mem[wr_ptr_r] <= res_nxt;
    end
  end

  assign head    = fifo_mem[rd_ptr_r];
  assign out_pop = out_ch.valid && out_ch.ready;

  always_comb begin
    wr_ptr_nxt   = c_r.vld ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt   = out_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    fifo_cnt_nxt = fifo_cnt_r + CNT_W'(c_r.vld) - CNT_W'(out_pop);
    credit_nxt   = credit_r + CNT_W'(step.res) - CNT_W'(out_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r   <= '0;
      rd_ptr_r   <= '0;
      fifo_cnt_r <= '0;
      credit_r   <= '0;
    end else begin
      wr_ptr_r   <= wr_ptr_nxt;
      rd_ptr_r   <= rd_ptr_nxt;
      fifo_cnt_r <= fifo_cnt_nxt;
      credit_r   <= credit_nxt;
    end
  end

  assign out_ch.valid        = fifo_cnt_r != '0;
  assign out_ch.result_rgb   = head.rgb;
  assign out_ch.end_of_line  = head.eol;
  assign out_ch.end_of_frame = head.eof;

  // ---------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------
  logic fifo_room;

  // a slot is free, or one leaves in the same cycle
  assign fifo_room = (fifo_cnt_r != CNT_W'(FIFO_DEPTH)) || out_pop;

  `FSAFF_ASSERT_HOLDS(a_credit_bound, credit_r <= CNT_W'(FIFO_DEPTH), "credits exceed fifo depth")
  `FSAFF_ASSERT_HOLDS(a_fifo_in_credit, fifo_cnt_r <= credit_r, "fifo holds uncredited beats")
  `FSAFF_ASSERT_IMPLIES(a_no_overflow, c_r.vld, fifo_room, "result written to full fifo")
  `FSAFF_ASSERT_IMPLIES(a_eof_is_eol, out_ch.valid && out_ch.end_of_frame, out_ch.end_of_line, "frame end off a line end")

endmodule

`default_nettype wire
